// File: rtl/core/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CDS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define CDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/cds_pkg.sv
// package of types and constants for the concentric disk sampler
package cds_pkg;

	localparam int SAMPLE_BITS      = 16;
	localparam int RESULT_FRAC_BITS = 14;
	localparam int unsigned CORDIC_STEPS = 30;
	localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
	localparam logic [31:0] EIGHTH_PHASE = 32'd536870912;

	// wedge region codes
	typedef enum logic [1:0] {
		REG_RIGHT = 2'd0,
		REG_TOP   = 2'd1,
		REG_LEFT  = 2'd2,
		REG_BOT   = 2'd3
	} region_t;

	// arctangent table, phase units with one turn = 2^32
	function automatic logic [31:0] atan_phase(input logic [4:0] idx);
		logic [31:0] v;
		unique case (idx)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/core/cds_front.sv
// front end: scales samples, picks the wedge region and its radius and numerator
module cds_front import cds_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [15:0]            first_uniform,
	input  logic [15:0]            second_uniform,
	output logic                   cl_valid,
	input  logic                   cl_stall,
	output logic                   cl_origin,
	output region_t                cl_region,
	output logic [SAMPLE_BITS:0]   cl_radius,
	output logic [SAMPLE_BITS+1:0] cl_numer
);

	localparam int SW = SAMPLE_BITS + 2;
	localparam int IW = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;

	logic [SAMPLE_BITS-1:0] u1, u2;
	logic signed [SW-1:0] sx, sy;
	logic origin;
	region_t region;
	logic [SAMPLE_BITS:0] radius;
	logic signed [SW-1:0] numer;
	logic valid_q;

	// mask inputs to the sample width and scale to 2u - 1
	always_comb begin
		u1 = '0;
		u2 = '0;
		u1[IW-1:0] = first_uniform[IW-1:0];
		u2[IW-1:0] = second_uniform[IW-1:0];
		sx = signed'({1'b0, u1, 1'b0}) - signed'(SW'(1) <<< SAMPLE_BITS);
		sy = signed'({1'b0, u2, 1'b0}) - signed'(SW'(1) <<< SAMPLE_BITS);
	end

	// region choice
	always_comb begin
		logic signed [SW-1:0] rs;
		rs = '0;
		origin = (sx == '0) && (sy == '0);
		if (sx >= -sy) begin
			if (sx > sy) begin
				region = REG_RIGHT; rs = sx; numer = sy;
			end else begin
				region = REG_TOP; rs = sy; numer = sx;
			end
		end else begin
			if (sx <= sy) begin
				region = REG_LEFT; rs = -sx; numer = sy;
			end else begin
				region = REG_BOT; rs = -sy; numer = sx;
			end
		end
		radius = rs[SAMPLE_BITS:0];
	end

	assign in_stall = valid_q && cl_stall;

	// output register toward the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cl_origin <= origin;
			cl_region <= region;
			cl_radius <= radius;
			cl_numer  <= numer;
		end
	end

	assign cl_valid = valid_q;

endmodule

// File: rtl/core/cds_queue.sv
// two-entry queue between front and back end
module cds_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_stall,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_stall,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic do_wr, do_rd;

	assign wr_stall = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign do_wr    = wr_valid && !wr_stall;
	assign do_rd    = rd_valid && !rd_stall;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) wp_q <= ~wp_q;
			if (do_rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_data;
	end

endmodule

// File: rtl/core/cds_back.sv
// back end: ratio division, phase, cordic pipeline, quadrant and rounding
module cds_back import cds_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cl_valid,
	output logic                   cl_stall,
	input  logic                   cl_origin,
	input  region_t                cl_region,
	input  logic [SAMPLE_BITS:0]   cl_radius,
	input  logic [SAMPLE_BITS+1:0] cl_numer,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [15:0]            disk_x,
	output logic [15:0]            disk_y
);

	// divider: 31 quotient bits of (a*2^30 + r) / (2r), one bit a stage
	localparam int QB  = 31;
	localparam int RW  = SAMPLE_BITS + 3;
	localparam int NDS = QB;
	localparam int NCS = CORDIC_STEPS;
	// entry stage, divider stages, phase stage, start-vector stage, cordic, output
	localparam int NST = 1 + NDS + 2 + NCS + 1;

	// pipeline control: whole pipeline advances when the output may move
	logic [NST-1:0] v_q;
	logic adv;
	assign adv      = !(v_q[NST-1] && out_stall);
	assign cl_stall = !adv;
	assign out_valid = v_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[NST-2:0], cl_valid};
		end
	end

	// divider stage registers
	logic [RW-1:0]          drem_q [NDS+1];
	logic [RW-1:0]          dden_q [NDS+1];
	logic [QB-1:0]          dquo_q [NDS+1];
	logic [SAMPLE_BITS:0]   drad_q [NDS+1];
	logic                   dneg_q [NDS+1];
	logic                   dorg_q [NDS+1];
	region_t                dreg_q [NDS+1];

	// magnitude of the wedge numerator
	logic [SAMPLE_BITS:0] abs_n;
	always_comb begin
		logic signed [SAMPLE_BITS+1:0] sn;
		sn = signed'(cl_numer);
		abs_n = sn[SAMPLE_BITS+1] ? (SAMPLE_BITS+1)'(0) - sn[SAMPLE_BITS:0]
			: sn[SAMPLE_BITS:0];
	end

	// dividend a*2^30 + r over divisor 2r rounds 2^29*a/r to nearest
	logic [SAMPLE_BITS+31:0] dividend;
	assign dividend = ({abs_n, 30'd0} + {{31{1'b0}}, cl_radius});

	logic [SAMPLE_BITS+31:0] dvd_q [NDS+1];

	// entry stage, dividend bits above the quotient bits form the first remainder
	always_ff @(posedge clk) begin
		if (adv) begin
			dvd_q[0]  <= dividend;
			drem_q[0] <= RW'(dividend >> QB);
			dden_q[0] <= RW'({cl_radius, 1'b0});
			dquo_q[0] <= '0;
			drad_q[0] <= cl_radius;
			dneg_q[0] <= cl_numer[SAMPLE_BITS+1];
			dorg_q[0] <= cl_origin;
			dreg_q[0] <= cl_region;
		end
	end

	// restoring division, bit QB-1-i in stage i
	genvar gi;
	generate
		for (gi = 0; gi < NDS; gi++) begin : g_div
			logic [RW:0] trial;
			logic bitq;
			always_comb begin
				trial = {drem_q[gi], dvd_q[gi][QB-1-gi]};
				bitq  = (trial >= {1'b0, dden_q[gi]});
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					drem_q[gi+1] <= bitq ? RW'(trial - {1'b0, dden_q[gi]}) : trial[RW-1:0];
					dquo_q[gi+1] <= {dquo_q[gi][QB-2:0], bitq};
					dvd_q[gi+1]  <= dvd_q[gi];
					dden_q[gi+1] <= dden_q[gi];
					drad_q[gi+1] <= drad_q[gi];
					dneg_q[gi+1] <= dneg_q[gi];
					dorg_q[gi+1] <= dorg_q[gi];
					dreg_q[gi+1] <= dreg_q[gi];
				end
			end
		end
	endgenerate

	// phase assembly: stage A
	logic [31:0] ph_sa;
	logic [SAMPLE_BITS:0] rad_sa;
	logic org_sa;
	always_ff @(posedge clk) begin
		logic [31:0] w, ph;
		w = dneg_q[NDS] ? 32'd0 - 32'(dquo_q[NDS]) : 32'(dquo_q[NDS]);
		unique case (dreg_q[NDS])
			REG_RIGHT: ph = w;
			REG_TOP:   ph = 32'd2 * EIGHTH_PHASE - w;
			REG_LEFT:  ph = 32'd4 * EIGHTH_PHASE - w;
			default:   ph = 32'd6 * EIGHTH_PHASE + w;
		endcase
		if (adv) begin
			ph_sa  <= ph;
			rad_sa <= drad_q[NDS];
			org_sa <= dorg_q[NDS];
		end
	end

	// quadrant, residual, and radius times inverse gain: stage B
	logic signed [34:0] x_c [NCS+1];
	logic signed [34:0] y_c [NCS+1];
	logic signed [33:0] z_c [NCS+1];
	logic [1:0] q_c [NCS+1];
	logic org_c [NCS+1];
	always_ff @(posedge clk) begin
		logic [1:0] qd;
		logic [31:0] rp;
		logic [SAMPLE_BITS+32:0] m;
		qd = 2'((ph_sa + EIGHTH_PHASE) >> 30);
		rp = ph_sa - {qd, 30'd0};
		m = (SAMPLE_BITS+33)'(rad_sa) * (SAMPLE_BITS+33)'(INV_GAIN_Q32);
		if (adv) begin
			x_c[0]   <= 35'((m + ((SAMPLE_BITS+33)'(1) << (SAMPLE_BITS-1))) >> SAMPLE_BITS);
			y_c[0]   <= '0;
			z_c[0]   <= 34'(signed'(rp));
			q_c[0]   <= qd;
			org_c[0] <= org_sa;
		end
	end

	// cordic rotation, one step per stage
	generate
		for (gi = 0; gi < NCS; gi++) begin : g_cor
			logic signed [34:0] dx, dy;
			logic [31:0] at;
			always_comb begin
				dx = y_c[gi] >>> gi;
				dy = x_c[gi] >>> gi;
				at = atan_phase(5'(gi));
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					if (!z_c[gi][33]) begin
						x_c[gi+1] <= x_c[gi] - dx;
						y_c[gi+1] <= y_c[gi] + dy;
						z_c[gi+1] <= z_c[gi] - signed'({2'b00, at});
					end else begin
						x_c[gi+1] <= x_c[gi] + dx;
						y_c[gi+1] <= y_c[gi] - dy;
						z_c[gi+1] <= z_c[gi] + signed'({2'b00, at});
					end
					q_c[gi+1]   <= q_c[gi];
					org_c[gi+1] <= org_c[gi];
				end
			end
		end
	endgenerate

	// quadrant fold, rounding and clamp into the output register
	function automatic logic [15:0] to_res(input logic signed [35:0] v);
		logic signed [35:0] t, one;
		one = 36'sd1 <<< RESULT_FRAC_BITS;
		t = (v + (36'sd1 <<< (31 - RESULT_FRAC_BITS))) >>> (32 - RESULT_FRAC_BITS);
		if (t > one) t = one;
		if (t < -one) t = -one;
		return t[15:0];
	endfunction

	always_ff @(posedge clk) begin
		logic signed [35:0] fx, fy, xx, yy;
		xx = 36'(x_c[NCS]);
		yy = 36'(y_c[NCS]);
		unique case (q_c[NCS])
			2'd0: begin fx = xx;  fy = yy;  end
			2'd1: begin fx = -yy; fy = xx;  end
			2'd2: begin fx = -xx; fy = -yy; end
			default: begin fx = yy; fy = -xx; end
		endcase
		if (adv) begin
			disk_x <= org_c[NCS] ? 16'd0 : to_res(fx);
			disk_y <= org_c[NCS] ? 16'd0 : to_res(fy);
		end
	end

endmodule

// File: rtl/core/concentric_disk_sample.sv
// Concentric disk sampler: one pair of Q0.16 uniforms in, one Q2.14 disk point out per request.
// A new request is taken every cycle while in_stall is low; an accepted request passes
// through one front register, one queue slot, an entry stage, a one-bit-a-stage divider
// (31 stages), a phase stage, a start-vector stage, a 30-stage CORDIC and the output
// register. A front stage classifies the wedge and feeds a two-entry queue to the back
// pipeline; a stalled output freezes the back pipeline and the queue absorbs two requests.
module concentric_disk_sample import cds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] first_uniform,
	input  logic [15:0] second_uniform,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [15:0] disk_x,
	output logic signed [15:0] disk_y
);

	localparam int QW = 1 + 2 + (SAMPLE_BITS + 1) + (SAMPLE_BITS + 2);

	logic f_valid, f_stall, b_valid, b_stall;
	logic f_origin;
	region_t f_region;
	logic [SAMPLE_BITS:0] f_radius;
	logic [SAMPLE_BITS+1:0] f_numer;
	logic [QW-1:0] q_out;
	logic [15:0] bx, by;

	// front end
	cds_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .first_uniform, .second_uniform,
		.cl_valid(f_valid), .cl_stall(f_stall), .cl_origin(f_origin),
		.cl_region(f_region), .cl_radius(f_radius), .cl_numer(f_numer)
	);

	// decoupling queue
	cds_queue #(.WIDTH(QW)) u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .wr_stall(f_stall),
		.wr_data({f_origin, f_region, f_radius, f_numer}),
		.rd_valid(b_valid), .rd_stall(b_stall), .rd_data(q_out)
	);

	// back end
	cds_back u_back (
		.clk, .arst_n, .cl_valid(b_valid), .cl_stall(b_stall),
		.cl_origin(q_out[QW-1]), .cl_region(region_t'(q_out[QW-2:QW-3])),
		.cl_radius(q_out[2*SAMPLE_BITS+2:SAMPLE_BITS+2]),
		.cl_numer(q_out[SAMPLE_BITS+1:0]),
		.out_valid, .out_stall, .disk_x(bx), .disk_y(by)
	);

	assign disk_x = signed'(bx);
	assign disk_y = signed'(by);

endmodule

// File: rtl/core/cds_checker.sv
// port-level checker for the concentric disk sampler, bound to the top level
`include "assert_macros.svh"
module cds_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic signed [15:0] disk_x,
	input logic signed [15:0] disk_y
);

	`CDS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(disk_x) && $stable(disk_y), "stalled result changed")
	`CDS_ASSERT_IMPL(a_x_range, clk, arst_n, out_valid, disk_x <= 16'sd16384 && disk_x >= -16'sd16384, "disk_x out of range")
	`CDS_ASSERT_IMPL(a_y_range, clk, arst_n, out_valid, disk_y <= 16'sd16384 && disk_y >= -16'sd16384, "disk_y out of range")
	`CDS_ASSERT_IMPL(a_no_stall_idle, clk, arst_n, !out_valid, !in_stall, "input stalled while output empty")

endmodule

bind concentric_disk_sample cds_checker u_cds_checker (
	.clk, .arst_n, .in_stall, .out_valid, .out_stall, .disk_x, .disk_y
);
